FILE: src/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, quiet during reset
`define ASSERT_IMPLIES(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

FILE: src/i2d_pkg.sv
package i2d_pkg;

  localparam int MaxPadDef = 32;
  localparam int MaxDigits = 20;
  localparam int BitsPerStage = 4;
  localparam int NumStages = 64 / BitsPerStage;   // four magnitude bits shifted in per stage
  localparam int CntW = 6;

  localparam logic [6:0] ChMinus = 7'h2d;
  localparam logic [6:0] ChPlus  = 7'h2b;
  localparam logic [6:0] ChZero  = 7'h30;

  typedef struct packed {
    logic [63:0] value;
    logic        is_signed;
    logic        show_plus;
    logic [5:0]  pad_width;
  } i2d_in_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } i2d_out_t;

  // one item travelling through the digit pipeline
  typedef struct packed {
    logic [63:0]       rem;      // magnitude bits not yet shifted in, msb first
    logic [MaxDigits*4-1:0] bcd; // digits found so far, least significant low
    logic              has_sign;
    logic [6:0]        sign_ch;
    logic [5:0]        pad;
  } i2d_work_t;

  // job handed to the serializer
  typedef struct packed {
    logic [MaxDigits*4-1:0] bcd;
    logic              has_sign;
    logic [6:0]        sign_ch;
    logic [5:0]        pad;
    logic [4:0]        nd;
  } i2d_job_t;

endpackage

FILE: src/i2d_stage.sv
// one pipeline stage: shift-and-add-3 over four magnitude bits
module i2d_stage import i2d_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      vld_i,
  input  i2d_work_t wrk_i,
  output logic      vld_o,
  output i2d_work_t wrk_o
);
  logic [63:0]            rem_v;
  logic [MaxDigits*4-1:0] bcd_v;
  i2d_work_t              wrk_nxt;
  logic                   vld_r;
  i2d_work_t              wrk_r;

  always_comb begin
    rem_v = wrk_i.rem;
    bcd_v = wrk_i.bcd;
    for (int s = 0; s < BitsPerStage; s++) begin
      // digits of 5 or more get 3 added so the shift carries into the next digit
      for (int d = 0; d < MaxDigits; d++) begin
        if (bcd_v[d*4 +: 4] >= 4'd5) bcd_v[d*4 +: 4] = bcd_v[d*4 +: 4] + 4'd3;
      end
      bcd_v = {bcd_v[MaxDigits*4-2:0], rem_v[63]};
      rem_v = {rem_v[62:0], 1'b0};
    end
    wrk_nxt = wrk_i;
    wrk_nxt.rem = rem_v;
    wrk_nxt.bcd = bcd_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
    if (adv) begin
      wrk_r <= wrk_nxt;
    end
  end

  assign vld_o = vld_r;
  assign wrk_o = wrk_r;
endmodule

FILE: src/i2d_emit.sv
// serializer: sign, pad zeros, then digits, one character per cycle
module i2d_emit import i2d_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_vld,
  input  i2d_job_t job,
  output logic     take,
  output logic     out_valid,
  output i2d_out_t out_item
);
  logic             act_r, act_nxt;
  i2d_job_t         job_r, job_nxt;
  logic [CntW-1:0]  left_r, left_nxt;   // characters still to send after this
  logic [CntW-1:0]  tot;
  logic [CntW-1:0]  ndig;
  logic [CntW-1:0]  pos;                // digit position from the right
  logic             in_sign;
  logic [3:0]       dg;
  logic [6:0]       ch;

  always_comb begin
    ndig = (job.pad > CntW'(job.nd)) ? job.pad : CntW'(job.nd);
    tot  = ndig + CntW'(job.has_sign);
    take = job_vld && (!act_r || left_r == '0);
  end

  always_comb begin
    in_sign = job_r.has_sign && (left_r == CntW'(
      ((job_r.pad > CntW'(job_r.nd)) ? job_r.pad : CntW'(job_r.nd))));
    pos = left_r;
    dg  = (pos < CntW'(job_r.nd)) ? job_r.bcd[pos[4:0]*4 +: 4] : 4'd0;
    ch  = in_sign ? job_r.sign_ch : (ChZero | {3'd0, dg});
    out_valid = act_r;
    out_item.char_code = ch;
    out_item.last = act_r && left_r == '0;
    act_nxt  = act_r && left_r != '0;
    left_nxt = left_r - CntW'(1);
    job_nxt  = job_r;
    if (take) begin
      act_nxt  = 1'b1;
      left_nxt = tot - CntW'(1);
      job_nxt  = job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
    left_r <= left_nxt;
    job_r  <= job_nxt;
  end
endmodule

FILE: src/int64_to_decimal_ascii.sv
// channel | ports                          | item accepted when
// input   | start, busy, in_item           | start && !busy at clk edge
// result  | out_valid, out_item            | out_valid at clk edge, no stall
//
// sixteen digit stages each shift four magnitude bits into a bcd register
// (shift and add-3 per bit); an accepted item passes the entry register, the
// digit stages and the serializer register; its text leaves at one character
// per cycle, 1 to MAX_PAD+1 characters (more if digits plus sign exceed it).
// the serializer is the rate limit: a new item enters whenever the pipe can
// shift, which stops only while the serializer still sends the previous text.
// reset is synchronous, clears valid bits and the serializer.
`include "assert_macros.svh"
module int64_to_decimal_ascii import i2d_pkg::*; #(
  parameter int MAX_PAD = MaxPadDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  i2d_in_t  in_item,
  output logic     out_valid,
  output i2d_out_t out_item
);
  logic      vld [NumStages+1];
  i2d_work_t wrk [NumStages+1];
  logic      adv;
  logic      take;
  logic      vld_in_r;
  i2d_work_t wrk_in_r, wrk_in_nxt;
  logic [5:0] pad_sat;
  logic      neg;
  i2d_job_t  job;
  logic [4:0] nd;

  // pipe shifts unless its tail holds an item the serializer cannot take
  assign adv  = !vld[NumStages] || take;
  assign busy = !adv;

  // entry stage: sign, magnitude, saturated width
  always_comb begin
    neg     = in_item.is_signed && in_item.value[63];
    pad_sat = (in_item.pad_width > 6'(MAX_PAD)) ? 6'(MAX_PAD) : in_item.pad_width;
    wrk_in_nxt.rem      = neg ? (64'd0 - in_item.value) : in_item.value;
    wrk_in_nxt.bcd      = '0;
    wrk_in_nxt.has_sign = neg || (in_item.is_signed && in_item.show_plus);
    wrk_in_nxt.sign_ch  = neg ? ChMinus : ChPlus;
    wrk_in_nxt.pad      = pad_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_in_r <= 1'b0;
    end else if (adv) begin
      vld_in_r <= start;
    end
    if (adv) begin
      wrk_in_r <= wrk_in_nxt;
    end
  end

  assign vld[0] = vld_in_r;
  assign wrk[0] = wrk_in_r;

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    i2d_stage u_stage (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .vld_i(vld[g]), .wrk_i(wrk[g]),
      .vld_o(vld[g+1]), .wrk_o(wrk[g+1])
    );
  end

  // digit count: highest nonzero digit, at least one
  always_comb begin
    nd = 5'd1;
    for (int i = 1; i < MaxDigits; i++) begin
      if (wrk[NumStages].bcd[i*4 +: 4] != 4'd0) nd = 5'(i + 1);
    end
    job.bcd      = wrk[NumStages].bcd;
    job.has_sign = wrk[NumStages].has_sign;
    job.sign_ch  = wrk[NumStages].sign_ch;
    job.pad      = wrk[NumStages].pad;
    job.nd       = nd;
  end

  i2d_emit u_emit (
    .clk(clk), .rst_n(rst_n),
    .job_vld(vld[NumStages]), .job(job),
    .take(take), .out_valid(out_valid), .out_item(out_item)
  );

  `ASSERT_IMPLIES(a_take_needs_job, clk, rst_n, take, vld[NumStages], "take without job")
  `ASSERT_NEXT(a_take_starts_out, clk, rst_n, take, out_valid, "job taken but no output")
  `ASSERT_IMPLIES(a_busy_tail, clk, rst_n, busy, vld[NumStages] && !take, "busy without cause")
endmodule
